// ===== design/quaternion_vector_rotation_assert.svh =====
// Assertion macros shared by the quaternion rotation design.
`ifndef QUATERNION_VECTOR_ROTATION_ASSERT_SVH
`define QUATERNION_VECTOR_ROTATION_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QVR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("quaternion_vector_rotation: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define QVR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("quaternion_vector_rotation: assertion failed");

`endif

// ===== design/qvr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package qvr_pkg;

    // Latency from an accepted start to the result strobe.
    localparam int LATENCY = 5;

    // Rounding bias for the final shift right by 28.
    localparam logic signed [49:0] RND_BIAS = 50'sd134217728;
    localparam logic signed [21:0] SAT_HI   = 22'sd32767;
    localparam logic signed [21:0] SAT_LO   = -22'sd32768;
    localparam logic signed [15:0] OUT_HI   = 16'sd32767;
    localparam logic signed [15:0] OUT_LO   = -16'sd32768;

    typedef struct packed {
        logic signed [15:0] w;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } quat_t;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } vec_t;

    // Intermediate quaternion t = q * (0, v): sums of three 32-bit products.
    typedef struct packed {
        logic signed [32:0] w;
        logic signed [32:0] x;
        logic signed [32:0] y;
        logic signed [32:0] z;
    } tquat_t;

    // Imaginary part of r = t * conj(q): sums of four 48-bit products.
    typedef struct packed {
        logic signed [49:0] x;
        logic signed [49:0] y;
        logic signed [49:0] z;
    } rvec_t;

endpackage

`default_nettype wire

// ===== design/qvr_tprod.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Two stages: twelve 16x16 products, then the four sums of t = q * (0, v).
module qvr_tprod (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  wire qvr_pkg::quat_t q_in,
    input  wire qvr_pkg::vec_t  v_in,
    output logic                t_valid,
    output qvr_pkg::quat_t      t_q,
    output qvr_pkg::tquat_t     t_out
);

    logic signed [31:0] p_reg  [12];
    logic signed [31:0] p_next [12];
    qvr_pkg::quat_t     qa_reg;
    logic               va_reg;

    qvr_pkg::tquat_t    t_reg;
    qvr_pkg::tquat_t    t_next;
    qvr_pkg::quat_t     qb_reg;
    logic               vb_reg;

    always_comb
    begin
        p_next[0]  = q_in.x * v_in.x;
        p_next[1]  = q_in.y * v_in.y;
        p_next[2]  = q_in.z * v_in.z;
        p_next[3]  = q_in.w * v_in.x;
        p_next[4]  = q_in.y * v_in.z;
        p_next[5]  = q_in.z * v_in.y;
        p_next[6]  = q_in.w * v_in.y;
        p_next[7]  = q_in.x * v_in.z;
        p_next[8]  = q_in.z * v_in.x;
        p_next[9]  = q_in.w * v_in.z;
        p_next[10] = q_in.x * v_in.y;
        p_next[11] = q_in.y * v_in.x;
    end

    always_comb
    begin
        t_next.w = -33'(p_reg[0]) - 33'(p_reg[1]) - 33'(p_reg[2]);
        t_next.x =  33'(p_reg[3]) + 33'(p_reg[4]) - 33'(p_reg[5]);
        t_next.y =  33'(p_reg[6]) - 33'(p_reg[7]) + 33'(p_reg[8]);
        t_next.z =  33'(p_reg[9]) + 33'(p_reg[10]) - 33'(p_reg[11]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg  <= p_next;
        qa_reg <= q_in;
        t_reg  <= t_next;
        qb_reg <= qa_reg;
    end

    assign t_valid = vb_reg;
    assign t_q     = qb_reg;
    assign t_out   = t_reg;

endmodule

`default_nettype wire

// ===== design/qvr_rprod.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Two stages: twelve 33x16 products, then the imaginary sums of r = t * conj(q).
module qvr_rprod (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            t_valid,
    input  wire qvr_pkg::quat_t  t_q,
    input  wire qvr_pkg::tquat_t t_in,
    output logic                 r_valid,
    output qvr_pkg::rvec_t       r_out
);

    logic signed [47:0] p_reg  [12];
    logic signed [47:0] p_next [12];
    logic               vc_reg;

    qvr_pkg::rvec_t     r_reg;
    qvr_pkg::rvec_t     r_next;
    logic               vd_reg;

    always_comb
    begin
        p_next[0]  = t_in.w * t_q.x;
        p_next[1]  = t_in.x * t_q.w;
        p_next[2]  = t_in.y * t_q.z;
        p_next[3]  = t_in.z * t_q.y;
        p_next[4]  = t_in.w * t_q.y;
        p_next[5]  = t_in.x * t_q.z;
        p_next[6]  = t_in.y * t_q.w;
        p_next[7]  = t_in.z * t_q.x;
        p_next[8]  = t_in.w * t_q.z;
        p_next[9]  = t_in.x * t_q.y;
        p_next[10] = t_in.y * t_q.x;
        p_next[11] = t_in.z * t_q.w;
    end

    always_comb
    begin
        r_next.x = -50'(p_reg[0]) + 50'(p_reg[1]) - 50'(p_reg[2])  + 50'(p_reg[3]);
        r_next.y = -50'(p_reg[4]) + 50'(p_reg[5]) + 50'(p_reg[6])  - 50'(p_reg[7]);
        r_next.z = -50'(p_reg[8]) - 50'(p_reg[9]) + 50'(p_reg[10]) + 50'(p_reg[11]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end
        else
        begin
            vc_reg <= t_valid;
            vd_reg <= vc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
        r_reg <= r_next;
    end

    assign r_valid = vd_reg;
    assign r_out   = r_reg;

endmodule

`default_nettype wire

// ===== design/qvr_round.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Final stage: round half up at bit 28, saturate to 16 bits, register the beat.
module qvr_round (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           r_valid,
    input  wire qvr_pkg::rvec_t r_in,
    output logic                strobe,
    output qvr_pkg::vec_t       rot,
    output logic                saturated
);

    typedef struct packed {
        logic               clip;
        logic signed [15:0] val;
    } sat_t;

    function automatic sat_t round_sat(input logic signed [49:0] a);
        logic signed [49:0] biased;
        logic signed [21:0] shifted;
        sat_t               res;
        biased  = a + qvr_pkg::RND_BIAS;
        // Bias cannot overflow: |a| stays below 2^49 minus the bias.
        shifted = biased[49:28];
        if (shifted > qvr_pkg::SAT_HI)
        begin
            res.clip = 1'b1;
            res.val  = qvr_pkg::OUT_HI;
        end
        else if (shifted < qvr_pkg::SAT_LO)
        begin
            res.clip = 1'b1;
            res.val  = qvr_pkg::OUT_LO;
        end
        else
        begin
            res.clip = 1'b0;
            res.val  = shifted[15:0];
        end
        return res;
    endfunction

    sat_t          sx;
    sat_t          sy;
    sat_t          sz;
    qvr_pkg::vec_t rot_reg;
    qvr_pkg::vec_t rot_next;
    logic          sat_reg;
    logic          sat_next;
    logic          strobe_reg;

    always_comb
    begin
        sx         = round_sat(r_in.x);
        sy         = round_sat(r_in.y);
        sz         = round_sat(r_in.z);
        rot_next.x = sx.val;
        rot_next.y = sy.val;
        rot_next.z = sz.val;
        sat_next   = sx.clip | sy.clip | sz.clip;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= r_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rot_reg <= rot_next;
        sat_reg <= sat_next;
    end

    assign strobe    = strobe_reg;
    assign rot       = rot_reg;
    assign saturated = sat_reg;

endmodule

`default_nettype wire

// ===== design/quaternion_vector_rotation.sv =====
// Quaternion vector rotation: rotates (vec_x, vec_y, vec_z) by the Q1.14
// quaternion (quat_w, quat_x, quat_y, quat_z) as q * (0, v) * conj(q).
// A quaternion that is not of unit length scales the result by its squared
// norm. Each output is rounded half up and saturated; saturated flags a clip.
// Input: a beat is taken at a rising edge where start is high and busy low.
// busy is high while reset is applied and is cleared by the clock after
// release; after that the block takes a beat on every cycle where start is
// high. Output: strobe is high for exactly one cycle per beat with rot_x,
// rot_y, rot_z and saturated valid; throughput is one beat per cycle.
// Pipeline: 16x16 products, t sums, 33x16 products, r sums, round/saturate.
// The latency is set by these five register stages; there is no stall path,
// since the receiver must take each result beat as it appears.
// Reset clears all valid bits, so no strobe appears from a beat in flight.
`timescale 1ns / 1ps
`default_nettype none
`include "quaternion_vector_rotation_assert.svh"

module quaternion_vector_rotation (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [15:0] quat_w,
    input  wire logic signed [15:0] quat_x,
    input  wire logic signed [15:0] quat_y,
    input  wire logic signed [15:0] quat_z,
    input  wire logic signed [15:0] vec_x,
    input  wire logic signed [15:0] vec_y,
    input  wire logic signed [15:0] vec_z,
    output logic                    strobe,
    output logic signed [15:0]      rot_x,
    output logic signed [15:0]      rot_y,
    output logic signed [15:0]      rot_z,
    output logic                    saturated
);

    logic            busy_reg;
    logic            in_valid;
    qvr_pkg::quat_t  q_in;
    qvr_pkg::vec_t   v_in;
    logic            t_valid;
    qvr_pkg::quat_t  t_q;
    qvr_pkg::tquat_t t_val;
    logic            r_valid;
    qvr_pkg::rvec_t  r_val;
    qvr_pkg::vec_t   rot;
    logic            rot_at_rail;
    logic            rot_zero;
    logic            quat_zero;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
        end
        else
        begin
            busy_reg <= 1'b0;
        end
    end

    assign busy     = busy_reg;
    assign in_valid = start & ~busy_reg;

    always_comb
    begin
        q_in.w = quat_w;
        q_in.x = quat_x;
        q_in.y = quat_y;
        q_in.z = quat_z;
        v_in.x = vec_x;
        v_in.y = vec_y;
        v_in.z = vec_z;
    end

    qvr_tprod u_tprod (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .q_in     (q_in),
        .v_in     (v_in),
        .t_valid  (t_valid),
        .t_q      (t_q),
        .t_out    (t_val)
    );

    qvr_rprod u_rprod (
        .clk      (clk),
        .rst_n    (rst_n),
        .t_valid  (t_valid),
        .t_q      (t_q),
        .t_in     (t_val),
        .r_valid  (r_valid),
        .r_out    (r_val)
    );

    qvr_round u_round (
        .clk       (clk),
        .rst_n     (rst_n),
        .r_valid   (r_valid),
        .r_in      (r_val),
        .strobe    (strobe),
        .rot       (rot),
        .saturated (saturated)
    );

    assign rot_x = rot.x;
    assign rot_y = rot.y;
    assign rot_z = rot.z;

    assign rot_at_rail = (rot_x == qvr_pkg::OUT_HI) || (rot_x == qvr_pkg::OUT_LO)
                      || (rot_y == qvr_pkg::OUT_HI) || (rot_y == qvr_pkg::OUT_LO)
                      || (rot_z == qvr_pkg::OUT_HI) || (rot_z == qvr_pkg::OUT_LO);
    assign rot_zero    = (rot_x == 16'sd0) && (rot_y == 16'sd0) && (rot_z == 16'sd0);
    assign quat_zero   = (quat_w == 16'sd0) && (quat_x == 16'sd0)
                      && (quat_y == 16'sd0) && (quat_z == 16'sd0);

    // Every accepted beat produces exactly one strobe, and no strobe appears without an accepted beat.
    `QVR_ASSERT_IMP(a_strobe_latency, clk, rst_n, 1'b1, strobe == $past(in_valid, 5))

    // A saturated beat has at least one component at a rail.
    `QVR_ASSERT_IMP(a_sat_at_rail, clk, rst_n, strobe && saturated, rot_at_rail)

    // A zero quaternion yields a zero, unsaturated result.
    `QVR_ASSERT_IMP(a_zero_quat, clk, rst_n, strobe && $past(in_valid && quat_zero, 5), rot_zero && !saturated)

    // Once out of reset, busy is cleared and stays low.
    `QVR_ASSERT_NXT(a_busy_clears, clk, rst_n, 1'b1, !busy)

endmodule

`default_nettype wire
